// ===== src/iocal_pkg.sv =====
// Shared types, constants and fixed-point helpers for the IMU calibrate and average block.
package iocal_pkg;

    // Block sizing
    localparam int AVERAGE_DEPTH = 10;
    localparam int CAL_SAMPLES   = 50;

    localparam int N_AXES = 3;
    localparam int N_CH   = 6;

    // Field widths
    localparam int RAW_W      = 16;
    localparam int Q4_W       = 20;
    localparam int ONEG_W     = 15;
    localparam int GS_W       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Calibration accumulators and offsets
    localparam int CAL_LOG = $clog2(CAL_SAMPLES);
    localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int ACAL_W  = 17 + CAL_LOG;    // sum of (raw - one g)
    localparam int RCAL_W  = 16 + CAL_LOG;    // sum of raw gyro counts
    localparam int RSCL_W  = RCAL_W + 4;      // gyro sum in Q.4
    localparam int AOFF_W  = 17;
    localparam int ROFF_W  = 21;

    // Moving window
    localparam int PTR_W   = $clog2(AVERAGE_DEPTH);
    localparam int WIN_LOG = $clog2(AVERAGE_DEPTH);
    localparam int WSUM_W  = Q4_W + WIN_LOG;
    localparam int HIST_W  = N_CH * Q4_W;

    // Corrected sample and rate scaling
    localparam int CORR_W    = 22;
    localparam int PROD_W    = Q4_W + GS_W + 1;
    localparam int DPS_SHIFT = 12;
    localparam int SAT_W     = PROD_W - DPS_SHIFT;

    // Exact reciprocals: m = ceil(2^(w+l) / d) gives floor(x / d) for x < 2^w
    localparam int          ACAL_SH = ACAL_W + CAL_LOG;
    localparam logic [63:0] ACAL_M  =
        ((64'd1 << ACAL_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam int          RSCL_SH = RSCL_W + CAL_LOG;
    localparam logic [63:0] RSCL_M  =
        ((64'd1 << RSCL_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam int          WSUM_SH = WSUM_W + WIN_LOG;
    localparam logic [63:0] WSUM_M  =
        ((64'd1 << WSUM_SH) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH);

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_G      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE = 1'b1;
    localparam logic [ONEG_W-1:0]    ONE_G_RESET      = 15'd4096;
    localparam logic [GS_W-1:0]      GYRO_SCALE_RESET = 16'd4000;

    typedef logic signed [RAW_W-1:0] t_raw;
    typedef logic signed [Q4_W-1:0]  t_q4;

    localparam t_q4 Q4_MAX = {1'b0, {(Q4_W-1){1'b1}}};
    localparam t_q4 Q4_MIN = {1'b1, {(Q4_W-1){1'b0}}};

    typedef struct packed {
        t_raw accel_x;
        t_raw accel_y;
        t_raw accel_z;
        t_raw rate_x;
        t_raw rate_y;
        t_raw rate_z;
        logic accel_cal_request;
        logic rate_cal_request;
    } t_in_item;

    typedef struct packed {
        t_q4  accel_x_avg;
        t_q4  accel_y_avg;
        t_q4  accel_z_avg;
        t_q4  rate_x_avg;
        t_q4  rate_y_avg;
        t_q4  rate_z_avg;
        t_q4  rate_x_dps;
        t_q4  rate_y_dps;
        t_q4  rate_z_dps;
        logic accel_cal_busy;
        logic rate_cal_busy;
    } t_out_item;

    // Stage load strobes from the pipeline control
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
    } t_pipe_ctl;

    typedef struct packed {
        logic accel;
        logic rate;
    } t_busy;

    typedef struct packed {
        t_q4 [N_CH-1:0] corr;
        t_busy          busy;
    } t_corr_item;

    typedef struct packed {
        t_q4 [N_CH-1:0] avg;
        t_busy          busy;
    } t_avg_item;

    // Accelerometer offset: sum / CAL_SAMPLES, truncated toward zero
    function automatic logic signed [AOFF_W-1:0] accel_offset(
        input logic signed [ACAL_W-1:0] sum);
        logic [ACAL_W-1:0]   mag;
        logic [2*ACAL_W:0]   prod;
        logic [ACAL_W-1:0]   quo;
        mag  = sum[ACAL_W-1] ? ACAL_W'(-sum) : ACAL_W'(sum);
        prod = (2*ACAL_W+1)'(mag) * (2*ACAL_W+1)'(ACAL_M);
        quo  = ACAL_W'(prod >> ACAL_SH);
        return sum[ACAL_W-1] ? $signed(AOFF_W'(-quo)) : $signed(AOFF_W'(quo));
    endfunction

    // Gyro offset in Q.4: (sum * 16) / CAL_SAMPLES, truncated toward zero
    function automatic logic signed [ROFF_W-1:0] rate_offset(
        input logic signed [RCAL_W-1:0] sum);
        logic signed [RSCL_W-1:0] scaled;
        logic [RSCL_W-1:0]        mag;
        logic [2*RSCL_W:0]        prod;
        logic [RSCL_W-1:0]        quo;
        scaled = {sum, 4'b0000};
        mag    = scaled[RSCL_W-1] ? RSCL_W'(-scaled) : RSCL_W'(scaled);
        prod   = (2*RSCL_W+1)'(mag) * (2*RSCL_W+1)'(RSCL_M);
        quo    = RSCL_W'(prod >> RSCL_SH);
        return scaled[RSCL_W-1] ? $signed(ROFF_W'(-quo)) : $signed(ROFF_W'(quo));
    endfunction

    // Window mean: sum / AVERAGE_DEPTH, truncated toward zero
    function automatic t_q4 win_avg(input logic signed [WSUM_W-1:0] sum);
        logic [WSUM_W-1:0] mag;
        logic [2*WSUM_W:0] prod;
        logic [WSUM_W-1:0] quo;
        mag  = sum[WSUM_W-1] ? WSUM_W'(-sum) : WSUM_W'(sum);
        prod = (2*WSUM_W+1)'(mag) * (2*WSUM_W+1)'(WSUM_M);
        quo  = WSUM_W'(prod >> WSUM_SH);
        return sum[WSUM_W-1] ? $signed(Q4_W'(-quo)) : $signed(Q4_W'(quo));
    endfunction

    // Clamp to the 20-bit Q.4 range
    function automatic t_q4 sat_q4(input logic signed [SAT_W-1:0] v);
        logic top_ones;
        logic top_zeros;
        top_ones  = &v[SAT_W-1:Q4_W-1];
        top_zeros = ~|v[SAT_W-1:Q4_W-1];
        if (top_ones || top_zeros) begin
            return $signed(v[Q4_W-1:0]);
        end
        return v[SAT_W-1] ? Q4_MIN : Q4_MAX;
    endfunction

endpackage

// ===== src/iocal_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module iocal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/iocal_calib.sv =====
// Bias calibration accumulators, offset computation and offset correction stages.
module iocal_calib (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iocal_pkg::t_pipe_ctl          i_ctl,
    input  iocal_pkg::t_in_item           i_in_data,
    input  logic [iocal_pkg::ONEG_W-1:0]  i_one_g,
    output iocal_pkg::t_corr_item         o_corr
);
    import iocal_pkg::*;

    t_raw                     raw [N_CH];

    // Calibration state
    logic signed [ACAL_W-1:0] r_acc_sum  [N_AXES];
    logic signed [ACAL_W-1:0] n_acc_sum  [N_AXES];
    logic signed [ACAL_W-1:0] acc_term   [N_AXES];
    logic signed [RCAL_W-1:0] r_rate_sum [N_AXES];
    logic signed [RCAL_W-1:0] n_rate_sum [N_AXES];
    logic [CNT_W-1:0]         r_acc_cnt;
    logic [CNT_W-1:0]         n_acc_cnt;
    logic [CNT_W-1:0]         r_rate_cnt;
    logic [CNT_W-1:0]         n_rate_cnt;
    logic                     r_acc_act;
    logic                     r_rate_act;
    logic                     acc_start;
    logic                     acc_run;
    logic                     acc_done;
    logic                     rate_start;
    logic                     rate_run;
    logic                     rate_done;

    // Stage 1: raw sample plus final sums when a calibration completes
    t_raw                     r_s1_raw      [N_CH];
    logic signed [ACAL_W-1:0] r_s1_acc_sum  [N_AXES];
    logic signed [RCAL_W-1:0] r_s1_rate_sum [N_AXES];
    logic                     r_s1_acc_done;
    logic                     r_s1_rate_done;
    t_busy                    r_s1_busy;

    // Offsets and stage 2
    logic signed [AOFF_W-1:0] r_acc_off  [N_AXES];
    logic signed [ROFF_W-1:0] r_rate_off [N_AXES];
    t_raw                     r_s2_raw   [N_CH];
    t_busy                    r_s2_busy;

    // Stage 3: corrected sample
    logic signed [CORR_W-1:0] acc_diff  [N_AXES];
    logic signed [CORR_W-1:0] rate_diff [N_AXES];
    t_q4 [N_CH-1:0]           n_corr;
    t_corr_item               r_s3;

    assign raw[0] = i_in_data.accel_x;
    assign raw[1] = i_in_data.accel_y;
    assign raw[2] = i_in_data.accel_z;
    assign raw[3] = i_in_data.rate_x;
    assign raw[4] = i_in_data.rate_y;
    assign raw[5] = i_in_data.rate_z;

    // Start, count and completion of both calibrations
    always_comb begin
        acc_start  = i_in_data.accel_cal_request && !r_acc_act;
        acc_run    = i_in_data.accel_cal_request || r_acc_act;
        n_acc_cnt  = (acc_start ? '0 : r_acc_cnt) + CNT_W'(1);
        acc_done   = acc_run && (n_acc_cnt == CNT_W'(CAL_SAMPLES));

        rate_start = i_in_data.rate_cal_request && !r_rate_act;
        rate_run   = i_in_data.rate_cal_request || r_rate_act;
        n_rate_cnt = (rate_start ? '0 : r_rate_cnt) + CNT_W'(1);
        rate_done  = rate_run && (n_rate_cnt == CNT_W'(CAL_SAMPLES));
    end

    // Running sums, current sample included; z loses one g
    always_comb begin
        acc_term[0] = ACAL_W'(raw[0]);
        acc_term[1] = ACAL_W'(raw[1]);
        acc_term[2] = ACAL_W'(raw[2]) - ACAL_W'($signed({1'b0, i_one_g}));
        for (int i = 0; i < N_AXES; i++) begin
            n_acc_sum[i]  = (acc_start ? '0 : r_acc_sum[i]) + acc_term[i];
            n_rate_sum[i] = (rate_start ? '0 : r_rate_sum[i]) + RCAL_W'(raw[N_AXES + i]);
        end
    end

    // Offset removal and clamp
    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            acc_diff[i]  = CORR_W'(r_s2_raw[i]) - CORR_W'(r_acc_off[i]);
            rate_diff[i] = (CORR_W'(r_s2_raw[N_AXES + i]) <<< 4) - CORR_W'(r_rate_off[i]);
            n_corr[i]          = sat_q4(SAT_W'(acc_diff[i] <<< 4));
            n_corr[N_AXES + i] = sat_q4(SAT_W'(rate_diff[i]));
        end
    end

    // Control state and offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_act  <= 1'b0;
            r_rate_act <= 1'b0;
            r_acc_cnt  <= '0;
            r_rate_cnt <= '0;
            for (int i = 0; i < N_AXES; i++) begin
                r_acc_off[i]  <= '0;
                r_rate_off[i] <= '0;
            end
        end else begin
            if (i_ctl.ld1 && acc_run) begin
                r_acc_act <= !acc_done;
                r_acc_cnt <= acc_done ? '0 : n_acc_cnt;
            end
            if (i_ctl.ld1 && rate_run) begin
                r_rate_act <= !rate_done;
                r_rate_cnt <= rate_done ? '0 : n_rate_cnt;
            end
            // new offsets are in place when the completing sample is corrected
            if (i_ctl.ld2 && r_s1_acc_done) begin
                for (int i = 0; i < N_AXES; i++) begin
                    r_acc_off[i] <= accel_offset(r_s1_acc_sum[i]);
                end
            end
            if (i_ctl.ld2 && r_s1_rate_done) begin
                for (int i = 0; i < N_AXES; i++) begin
                    r_rate_off[i] <= rate_offset(r_s1_rate_sum[i]);
                end
            end
        end
    end

    // Sums and pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1 && acc_run) begin
            r_acc_sum <= n_acc_sum;
        end
        if (i_ctl.ld1 && rate_run) begin
            r_rate_sum <= n_rate_sum;
        end
        if (i_ctl.ld1) begin
            r_s1_raw        <= raw;
            r_s1_acc_sum    <= n_acc_sum;
            r_s1_rate_sum   <= n_rate_sum;
            r_s1_acc_done   <= acc_done;
            r_s1_rate_done  <= rate_done;
            r_s1_busy.accel <= acc_run && !acc_done;
            r_s1_busy.rate  <= rate_run && !rate_done;
        end
        if (i_ctl.ld2) begin
            r_s2_raw  <= r_s1_raw;
            r_s2_busy <= r_s1_busy;
        end
        if (i_ctl.ld3) begin
            r_s3.corr <= n_corr;
            r_s3.busy <= r_s2_busy;
        end
    end

    assign o_corr = r_s3;

endmodule

// ===== src/iocal_window.sv =====
// Moving-window averager: sample history in RAM, running sums and the window mean.
module iocal_window (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  iocal_pkg::t_pipe_ctl   i_ctl,
    input  iocal_pkg::t_corr_item  i_corr,
    output iocal_pkg::t_avg_item   o_avg
);
    import iocal_pkg::*;

    logic [PTR_W-1:0]         r_rd_ptr;
    logic [PTR_W-1:0]         n_rd_ptr;
    logic [PTR_W-1:0]         r_s3_slot;
    logic [AVERAGE_DEPTH-1:0] r_hist_vld;
    logic                     r_old_vld;
    logic [HIST_W-1:0]        rd_data;
    t_q4                      old_smp [N_CH];
    logic signed [WSUM_W-1:0] r_wsum  [N_CH];
    logic signed [WSUM_W-1:0] n_wsum  [N_CH];
    t_busy                    r_s4_busy;
    t_avg_item                r_s5;

    // History of corrected samples, one row per window slot
    iocal_ram #(
        .WIDTH (HIST_W),
        .DEPTH (AVERAGE_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.ld4),
        .i_wr_addr (r_s3_slot),
        .i_wr_data (i_corr.corr),
        .i_rd_en   (i_ctl.ld3),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    assign n_rd_ptr = (r_rd_ptr == PTR_W'(AVERAGE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);

    // Swap the oldest sample for the new one; unwritten slots read as zero
    always_comb begin
        for (int i = 0; i < N_CH; i++) begin
            old_smp[i] = r_old_vld ? $signed(rd_data[i*Q4_W +: Q4_W]) : '0;
            n_wsum[i]  = r_wsum[i] + WSUM_W'($signed(i_corr.corr[i])) - WSUM_W'(old_smp[i]);
        end
    end

    // Slot pointer, valid bits and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= '0;
            r_hist_vld <= '0;
            for (int i = 0; i < N_CH; i++) begin
                r_wsum[i] <= '0;
            end
        end else begin
            if (i_ctl.ld3) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_ctl.ld4) begin
                r_hist_vld[r_s3_slot] <= 1'b1;
                r_wsum                <= n_wsum;
            end
        end
    end

    // Slot tag, then the mean of the sums left by the item in stage 4
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_s3_slot <= r_rd_ptr;
            r_old_vld <= r_hist_vld[r_rd_ptr];
        end
        if (i_ctl.ld4) begin
            r_s4_busy <= i_corr.busy;
        end
        if (i_ctl.ld5) begin
            for (int i = 0; i < N_CH; i++) begin
                r_s5.avg[i] <= win_avg(r_wsum[i]);
            end
            r_s5.busy <= r_s4_busy;
        end
    end

    assign o_avg = r_s5;

endmodule

// ===== src/imu_offset_calibrate_and_average_top.sv =====
// Top level of the IMU calibrate and average block: handshake, registers and rate scaling.
//
// One six-axis sample is taken per clock while the input is not stalled, and each gives
// one result. Stage 1 updates the bias-calibration sums, stage 2 turns finished sums
// into offsets (one reciprocal multiply per axis), stage 3 removes the offsets and
// clamps as the oldest sample of the window is read from the history RAM, and stage 4
// writes the new sample over it and updates the running sums. Stages 5 to 7 form the
// window mean, multiply the gyro means by gyro_scale and clamp the result. The RAM
// holds AVERAGE_DEPTH rows of six corrected samples; one valid bit per row makes the
// window start from zero after reset, so there is no clearing pass and the block is
// ready at once. Each stage holds its item while the next is full, so bubbles close up
// and input transfers continue while a result waits at the output, until every stage
// is full. Registers should be written only while no item is in flight.
module imu_offset_calibrate_and_average_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  iocal_pkg::t_in_item              i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output iocal_pkg::t_out_item             o_out_data,
    input  logic                             i_cfg_we,
    input  logic [iocal_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [iocal_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import iocal_pkg::*;

    localparam int STAGES = 7;

    logic [ONEG_W-1:0]        r_one_g;
    logic [GS_W-1:0]          r_gyro_scale;
    logic [STAGES:1]          r_vld;
    logic [STAGES:1]          n_vld;
    logic [STAGES+1:1]        rdy;
    logic [STAGES:1]          ld;
    t_pipe_ctl                ctl;
    t_corr_item               corr;
    t_avg_item                avg;
    t_avg_item                r_s6;
    logic signed [PROD_W-1:0] r_s6_prod [N_AXES];
    t_q4                      dps       [N_AXES];
    t_out_item                r_out;

    // Stage occupancy: a stage takes a new item when it is empty or draining
    always_comb begin
        rdy[STAGES+1] = !i_out_stall;
        for (int k = STAGES; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        ld[1] = i_in_valid && rdy[1];
        for (int k = 2; k <= STAGES; k++) begin
            ld[k] = r_vld[k-1] && rdy[k];
        end
        for (int k = 1; k <= STAGES; k++) begin
            n_vld[k] = ld[k] || (r_vld[k] && !rdy[k+1]);
        end
    end

    assign ctl.ld1 = ld[1];
    assign ctl.ld2 = ld[2];
    assign ctl.ld3 = ld[3];
    assign ctl.ld4 = ld[4];
    assign ctl.ld5 = ld[5];

    assign o_in_stall  = !rdy[1];
    assign o_out_valid = r_vld[STAGES];
    assign o_out_data  = r_out;

    // Valid bits and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_one_g      <= ONE_G_RESET;
            r_gyro_scale <= GYRO_SCALE_RESET;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ONE_G:      r_one_g      <= i_cfg_data[ONEG_W-1:0];
                    CFG_GYRO_SCALE: r_gyro_scale <= i_cfg_data[GS_W-1:0];
                endcase
            end
        end
    end

    iocal_calib u_calib (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_in_data (i_in_data),
        .i_one_g   (r_one_g),
        .o_corr    (corr)
    );

    iocal_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_corr  (corr),
        .o_avg   (avg)
    );

    // Floor shift by 12, then clamp to Q.4 in 20 bits
    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            dps[i] = sat_q4($signed(r_s6_prod[i][PROD_W-1:DPS_SHIFT]));
        end
    end

    // Stage 6: gyro means times scale; stage 7: output register
    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            r_s6 <= avg;
            for (int i = 0; i < N_AXES; i++) begin
                r_s6_prod[i] <= PROD_W'($signed(avg.avg[N_AXES + i]))
                              * PROD_W'($signed({1'b0, r_gyro_scale}));
            end
        end
        if (ld[7]) begin
            r_out.accel_x_avg    <= r_s6.avg[0];
            r_out.accel_y_avg    <= r_s6.avg[1];
            r_out.accel_z_avg    <= r_s6.avg[2];
            r_out.rate_x_avg     <= r_s6.avg[3];
            r_out.rate_y_avg     <= r_s6.avg[4];
            r_out.rate_z_avg     <= r_s6.avg[5];
            r_out.rate_x_dps     <= dps[0];
            r_out.rate_y_dps     <= dps[1];
            r_out.rate_z_dps     <= dps[2];
            r_out.accel_cal_busy <= r_s6.busy.accel;
            r_out.rate_cal_busy  <= r_s6.busy.rate;
        end
    end

endmodule
